@@ rtl/ibp_pkg.sv @@
// Shared types and constants for the instruction byte predecoder.
// No dependencies; compiled first.
package ibp_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] NOP_BYTE  = 8'hAE;
	localparam logic [7:0] RJMP_BYTE = 8'hAF;

	localparam logic [1:0] CLS_RR     = 2'd0;
	localparam logic [1:0] CLS_RI     = 2'd1;
	localparam logic [1:0] CLS_JMP    = 2'd2;
	localparam logic [1:0] CLS_PREFIX = 2'd3;

	typedef enum logic [2:0] {
		FORM_ILLEGAL = 3'd0,
		FORM_NOP     = 3'd1,
		FORM_RR      = 3'd2,
		FORM_RI      = 3'd3,
		FORM_RJMP    = 3'd4,
		FORM_IJMP    = 3'd5
	} form_t;

	// what the front has decided about a finished instruction
	typedef enum logic [1:0] {
		KIND_ILLEGAL = 2'd0,
		KIND_NOP     = 2'd1,
		KIND_PAIR    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic [3:0]  prefix;    // x bit 0, b bit 1, a bit 2, q bit 3
		logic [1:0]  length;
	} insn_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ rtl/ibp_if.sv @@
// Valid/ready channel interfaces: code byte input and decoded result output.
// No dependencies.
interface ibp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface ibp_res_if;
	logic              valid;
	logic              ready;
	logic [2:0]        form;
	logic [1:0]        operand_size;
	logic [4:0]        operation;
	logic [3:0]        first_register;
	logic [3:0]        second_register;
	logic signed [8:0] immediate;
	logic [1:0]        byte_length;
	logic              wide_flag;

	modport source (output valid, output form, output operand_size, output operation,
		output first_register, output second_register, output immediate,
		output byte_length, output wide_flag, input ready);
	modport sink (input valid, input form, input operand_size, input operation,
		input first_register, input second_register, input immediate,
		input byte_length, input wide_flag, output ready);
endinterface

@@ rtl/ibp_front.sv @@
// Front end: takes code bytes, tracks prefix and first byte, pushes finished
// instructions into the queue. Depends on ibp_pkg and ibp_if.
module ibp_front import ibp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ibp_byte_if.sink    in_ch,
	input  q_status_t   q_status,
	output logic        push,
	output insn_t       push_insn
);

	logic       awaiting_q;
	logic [7:0] held_q;
	logic       pfx_seen_q;
	logic [3:0] pfx_q;
	logic [1:0] count_q;

	logic       accept;
	logic [7:0] b;
	logic [1:0] count_inc;

	assign in_ch.ready = !q_status.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.code_byte;
	assign count_inc   = count_q + 2'd1;

	always_comb begin
		push                   = 1'b0;
		push_insn.kind         = KIND_ILLEGAL;
		push_insn.first_byte   = held_q;
		push_insn.second_byte  = b;
		push_insn.prefix       = pfx_q;
		push_insn.length       = count_inc;
		if (accept) begin
			if (awaiting_q) begin
				push           = 1'b1;
				push_insn.kind = KIND_PAIR;
			end else if (b[7:6] == CLS_PREFIX) begin
				// reserved prefix bits or a second prefix
				push = (b[5:4] != 2'b00) || pfx_seen_q;
			end else if (b == NOP_BYTE) begin
				push           = 1'b1;
				push_insn.kind = KIND_NOP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			pfx_seen_q <= 1'b0;
			pfx_q      <= 4'd0;
			count_q    <= 2'd0;
		end else if (accept) begin
			if (push) begin
				awaiting_q <= 1'b0;
				pfx_seen_q <= 1'b0;
				pfx_q      <= 4'd0;
				count_q    <= 2'd0;
			end else if (b[7:6] == CLS_PREFIX) begin
				pfx_seen_q <= 1'b1;
				pfx_q      <= b[3:0];
				count_q    <= count_inc;
			end else begin
				awaiting_q <= 1'b1;
				count_q    <= count_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !push && b[7:6] != CLS_PREFIX) begin
			held_q <= b;
		end
	end

endmodule

@@ rtl/ibp_queue.sv @@
// Small flop-based FIFO between front and back end.
// Depends on ibp_pkg.
module ibp_queue import ibp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  insn_t     push_insn,
	input  logic      pop,
	output insn_t     head,
	output q_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	insn_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_insn;
	end

endmodule

@@ rtl/ibp_back.sv @@
// Back end: decodes queued instructions into result fields and holds them
// in the output register. Holds the signed-immediate opcode mask.
// Depends on ibp_pkg and ibp_if.
module ibp_back import ibp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  insn_t       head,
	input  q_status_t   q_status,
	output logic        pop,
	ibp_res_if.source   out_ch
);

	logic [15:0] mask_q;
	logic        valid_q;

	form_t             d_form;
	logic [1:0]        d_size;
	logic [4:0]        d_op;
	logic [3:0]        d_r1;
	logic [3:0]        d_r2;
	logic [8:0]        d_imm;
	logic              d_wide;
	logic [7:0]        b0;
	logic [7:0]        b1;
	logic [3:0]        ra;
	logic              sext;

	assign b0   = head.first_byte;
	assign b1   = head.second_byte;
	assign ra   = {head.prefix[2], b1[7:5]};
	assign sext = mask_q[b0[3:0]] && b1[4];

	always_comb begin
		d_form = FORM_ILLEGAL;
		d_size = 2'd0;
		d_op   = 5'd0;
		d_r1   = 4'd0;
		d_r2   = 4'd0;
		d_imm  = 9'd0;
		case (head.kind)
			KIND_NOP: d_form = FORM_NOP;
			KIND_PAIR: begin
				if (b0[7:6] == CLS_RR) begin
					if (b1[1:0] == 2'b00) begin
						d_form = FORM_RR;
						d_size = b0[5:4];
						d_op   = {1'b0, b0[3:0]};
						d_r1   = ra;
						d_r2   = {head.prefix[1], b1[4:2]};
					end
				end else if (b0[7:6] == CLS_RI) begin
					d_form = FORM_RI;
					d_size = b0[5:4];
					d_op   = {1'b0, b0[3:0]};
					d_r1   = ra;
					d_imm  = {{4{sext}}, b1[4:0]};
				end else if (b0 == RJMP_BYTE) begin
					d_form = FORM_RJMP;
					d_op   = b1[4:0];
					d_r1   = {1'b0, b1[7:5]};
				end else if (b0[7:6] == CLS_JMP && !b0[5]) begin
					d_form = FORM_IJMP;
					d_op   = {1'b0, b0[3:0]};
					d_imm  = {b0[4], b1};
				end
			end
			default: d_form = FORM_ILLEGAL;
		endcase
		d_wide = (d_form != FORM_ILLEGAL) && head.prefix[3];
	end

	assign pop = !q_status.empty && (!valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= 16'd0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) mask_q <= cfg_wdata;
			if (pop) valid_q <= 1'b1;
			else if (out_ch.ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_ch.form            <= d_form;
			out_ch.operand_size    <= d_size;
			out_ch.operation       <= d_op;
			out_ch.first_register  <= d_r1;
			out_ch.second_register <= d_r2;
			out_ch.immediate       <= d_imm;
			out_ch.byte_length     <= head.length;
			out_ch.wide_flag       <= d_wide;
		end
	end

	assign out_ch.valid = valid_q;

endmodule

@@ rtl/instruction_byte_predecoder_unit.sv @@
// Top level of the instruction byte predecoder: front end, queue, back end.
// Depends on ibp_pkg, ibp_if, ibp_front, ibp_queue, ibp_back.

// Takes one code byte per cycle while input ready is high. The byte that
// completes an instruction is pushed into the queue (front end tracks prefix
// and first byte in the accept cycle); the back end then decodes it out of the
// queue into the output register. Valid prefix bytes and first bytes of
// two-byte instructions produce no result. The queue (DEPTH entries)
// absorbs output stalls; input ready drops only when it is full.
module instruction_byte_predecoder_unit import ibp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	ibp_byte_if.sink    in_ch,
	ibp_res_if.source   out_ch
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	insn_t     push_insn;
	insn_t     head;

	ibp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.q_status  (q_status),
		.push      (push),
		.push_insn (push_insn)
	);

	ibp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_insn (push_insn),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	ibp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_ch    (out_ch)
	);

`ifndef SYNTH
	// never push into a full queue without a pop, or pop an empty one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_status.empty))
		else $error("queue underflow");

	// illegal results carry nothing but form and length
	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.form == FORM_ILLEGAL) |->
		(out_ch.wide_flag == 1'b0 && out_ch.operand_size == 2'd0 &&
		out_ch.immediate == 9'sd0))
		else $error("illegal result with nonzero payload");

	// an instruction pushed into an empty queue while the output is idle is then popped without waiting
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && q_status.empty && !out_ch.valid) |=> pop)
		else $error("back end missed a queued instruction");
`endif

endmodule
